[rtl/bpdr_pkg.sv]
`default_nettype none

package bpdr_pkg;

	localparam int REF_W  = 10;
	localparam int COEF_W = 16;
	localparam int ERR_W  = 11;
	localparam int CTL_W  = 11;
	localparam int PROD_W = COEF_W + ERR_W;
	localparam int ACC_W  = PROD_W + 3;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 3;

	typedef logic signed [ERR_W-1:0]  err_t;
	typedef logic signed [CTL_W-1:0]  ctl_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [ACC_W-1:0]  acc_t;

	typedef enum logic [IDX_W-1:0] {
		REG_REFERENCE = 3'd0,
		REG_COEF_B0   = 3'd1,
		REG_COEF_B1   = 3'd2,
		REG_COEF_B2   = 3'd3,
		REG_COEF_A1   = 3'd4,
		REG_COEF_A2   = 3'd5
	} reg_idx_t;

	localparam logic [REF_W-1:0] REFERENCE_RST = 10'd512;
	localparam coef_t COEF_B0_RST = -16'sd3;
	localparam coef_t COEF_B1_RST = -16'sd2;
	localparam coef_t COEF_B2_RST = 16'sd0;
	localparam coef_t COEF_A1_RST = 16'sd0;
	localparam coef_t COEF_A2_RST = -16'sd1;

	localparam acc_t ACC_POS_LIM = 30'sd512;
	localparam acc_t ACC_NEG_LIM = -30'sd512;
	localparam ctl_t U_POS_LIM   = 11'sd512;
	localparam ctl_t U_NEG_LIM   = -11'sd512;
	localparam logic [CTL_W-1:0] DUTY_MID = 11'd512;

endpackage

`default_nettype wire

[rtl/buck_pid_duty_regulator.sv]
`default_nettype none

// channel   direction  handshake              payload
// in        sink       in_valid / in_stall    adc_sample [9:0]
// out       source     out_valid / out_stall  duty_value [10:0], control_value [10:0], saturated
// cfg       sink       cfg_we                 cfg_index [2:0], cfg_data [15:0]
//
// one request per cycle sustained unless out_stall holds; requests enter the sample register
// the difference equation is combinational between the sample register and the result register
// arst_n clears the configuration registers to their power-up values and both histories to zero
// in_stall rises only while both stages are full and out_stall holds the result

module buck_pid_duty_regulator
	import bpdr_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output      logic                in_stall,
	input  wire logic [REF_W-1:0]    adc_sample,
	output      logic                out_valid,
	input  wire logic                out_stall,
	output      logic [CTL_W-1:0]    duty_value,
	output      logic signed [CTL_W-1:0] control_value,
	output      logic                saturated,
	input  wire logic                cfg_we,
	input  wire logic [IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_W-1:0]    cfg_data
);

	logic [REF_W-1:0] reference_q;
	coef_t coef_b0_q, coef_b1_q, coef_b2_q, coef_a1_q, coef_a2_q;

	err_t e1_q, e2_q;
	ctl_t u1_q, u2_q;

	logic             valid_s1;
	logic [REF_W-1:0] sample_s1;

	logic                valid_s2;
	logic [CTL_W-1:0]    duty_s2;
	ctl_t                ctl_s2;
	logic                sat_s2;

	logic  adv_s2, take_s1;
	err_t  e0;
	prod_t p_b0, p_b1, p_b2, p_a1, p_a2;
	acc_t  acc;
	ctl_t  u_next;
	logic  sat_next;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reference_q <= REFERENCE_RST;
			coef_b0_q   <= COEF_B0_RST;
			coef_b1_q   <= COEF_B1_RST;
			coef_b2_q   <= COEF_B2_RST;
			coef_a1_q   <= COEF_A1_RST;
			coef_a2_q   <= COEF_A2_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_REFERENCE: reference_q <= cfg_data[REF_W-1:0];
				REG_COEF_B0:   coef_b0_q   <= coef_t'(cfg_data);
				REG_COEF_B1:   coef_b1_q   <= coef_t'(cfg_data);
				REG_COEF_B2:   coef_b2_q   <= coef_t'(cfg_data);
				REG_COEF_A1:   coef_a1_q   <= coef_t'(cfg_data);
				REG_COEF_A2:   coef_a2_q   <= coef_t'(cfg_data);
				default: ;
			endcase
		end
	end

	// handshake
	assign adv_s2   = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv_s2;
	assign take_s1  = valid_s1 && adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			sample_s1 <= adc_sample;
		end
	end

	// difference equation
	always_comb begin
		e0   = err_t'({1'b0, reference_q}) - err_t'({1'b0, sample_s1});
		p_b0 = prod_t'(coef_b0_q) * prod_t'(e0);
		p_b1 = prod_t'(coef_b1_q) * prod_t'(e1_q);
		p_b2 = prod_t'(coef_b2_q) * prod_t'(e2_q);
		p_a1 = prod_t'(coef_a1_q) * prod_t'(u1_q);
		p_a2 = prod_t'(coef_a2_q) * prod_t'(u2_q);
		acc  = acc_t'(p_b0) + acc_t'(p_b1) + acc_t'(p_b2) - acc_t'(p_a1) - acc_t'(p_a2);
		if (acc > ACC_POS_LIM) begin
			u_next   = U_POS_LIM;
			sat_next = 1'b1;
		end else if (acc < ACC_NEG_LIM) begin
			u_next   = U_NEG_LIM;
			sat_next = 1'b1;
		end else begin
			u_next   = ctl_t'(acc);
			sat_next = 1'b0;
		end
	end

	// histories
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e1_q <= '0;
			e2_q <= '0;
			u1_q <= '0;
			u2_q <= '0;
		end else if (take_s1) begin
			e1_q <= e0;
			e2_q <= e1_q;
			u1_q <= u_next;
			u2_q <= u1_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			ctl_s2  <= u_next;
			duty_s2 <= DUTY_MID + CTL_W'(u_next);
			sat_s2  <= sat_next;
		end
	end

	assign out_valid     = valid_s2;
	assign duty_value    = duty_s2;
	assign control_value = ctl_s2;
	assign saturated     = sat_s2;

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && sat_s2 |-> ctl_s2 == U_POS_LIM || ctl_s2 == U_NEG_LIM)
		else $error("saturated result not at a limit");

	a_duty_matches: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> duty_s2 == DUTY_MID + CTL_W'(ctl_s2))
		else $error("duty does not track control value");

	a_hist_follows: assert property (@(posedge clk) disable iff (!arst_n)
		take_s1 |=> u1_q == ctl_s2 && valid_s2)
		else $error("control history out of step with result");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled with room available");

endmodule

`default_nettype wire

[sim/bpdr_duty_checker.sv]
module bpdr_duty_checker
	import bpdr_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	input  wire logic                    in_stall,
	input  wire logic [REF_W-1:0]        adc_sample,
	input  wire logic                    out_valid,
	input  wire logic                    out_stall,
	input  wire logic [CTL_W-1:0]        duty_value,
	input  wire logic signed [CTL_W-1:0] control_value,
	input  wire logic                    saturated,
	input  wire logic                    cfg_we,
	input  wire logic [IDX_W-1:0]        cfg_index,
	input  wire logic [CFG_W-1:0]        cfg_data,
	output int                           mismatches,
	output int                           outstanding
);

	typedef struct packed {
		logic [CTL_W-1:0] duty;
		ctl_t             control;
		logic             clipped;
	} duty_result_t;

	logic [REF_W-1:0] setpoint;
	coef_t            b0, b1, b2, a1, a2;
	err_t             err_prev, err_prev2;
	ctl_t             ctl_prev, ctl_prev2;
	duty_result_t     duty_expected[$];
	duty_result_t     next_result;
	int               fail_tally = 0;
	int               result_no = 0;

	task automatic report_mismatch(input string msg);
		$display("duty checker: result %0d: %s", result_no, msg);
		fail_tally++;
	endtask

	task automatic regulate_adc(input logic [REF_W-1:0] level, output duty_result_t res);
		longint acc;
		err_t   e_now;
		e_now = err_t'(int'(setpoint) - int'(level));
		acc = longint'(b0) * longint'(e_now) + longint'(b1) * longint'(err_prev)
			+ longint'(b2) * longint'(err_prev2) - longint'(a1) * longint'(ctl_prev)
			- longint'(a2) * longint'(ctl_prev2);
		res.clipped = 1'b1;
		if (acc > longint'(U_POS_LIM)) begin
			res.control = U_POS_LIM;
		end else if (acc < longint'(U_NEG_LIM)) begin
			res.control = U_NEG_LIM;
		end else begin
			res.control = ctl_t'(acc);
			res.clipped = 1'b0;
		end
		res.duty = DUTY_MID + res.control;
		err_prev2 = err_prev;
		err_prev = e_now;
		ctl_prev2 = ctl_prev;
		ctl_prev = res.control;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint = REFERENCE_RST;
			b0 = COEF_B0_RST;
			b1 = COEF_B1_RST;
			b2 = COEF_B2_RST;
			a1 = COEF_A1_RST;
			a2 = COEF_A2_RST;
			err_prev = '0;
			err_prev2 = '0;
			ctl_prev = '0;
			ctl_prev2 = '0;
			duty_expected.delete();
			mismatches <= fail_tally;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_REFERENCE: setpoint = cfg_data[REF_W-1:0];
					REG_COEF_B0:   b0 = cfg_data;
					REG_COEF_B1:   b1 = cfg_data;
					REG_COEF_B2:   b2 = cfg_data;
					REG_COEF_A1:   a1 = cfg_data;
					REG_COEF_A2:   a2 = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				regulate_adc(adc_sample, next_result);
				duty_expected.push_back(next_result);
			end
			if (out_valid && !out_stall) begin
				if (duty_expected.size() == 0) begin
					report_mismatch($sformatf("unrequested result duty %0d control %0d",
						duty_value, control_value));
				end else begin
					next_result = duty_expected.pop_front();
					if (duty_value !== next_result.duty)
						report_mismatch($sformatf("duty_value got %0d want %0d",
							duty_value, next_result.duty));
					if (control_value !== next_result.control)
						report_mismatch($sformatf("control_value got %0d want %0d",
							control_value, next_result.control));
					if (saturated !== next_result.clipped)
						report_mismatch($sformatf("saturated got %b want %b",
							saturated, next_result.clipped));
				end
				result_no++;
			end
			mismatches <= fail_tally;
			outstanding <= duty_expected.size();
		end
	end

endmodule

[sim/testbench.sv]
module testbench;
	import bpdr_pkg::*;

	localparam logic [IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_7 = 3'd7;
	localparam logic [CFG_W-1:0] COEF_MIN = 16'h8000;
	localparam logic [CFG_W-1:0] COEF_MAX = 16'h7FFF;
	localparam logic [CFG_W-1:0] COEF_ONE = 16'h0001;
	localparam logic [CFG_W-1:0] COEF_ZERO = 16'h0000;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_REQUESTS = 158;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [REF_W-1:0]        adc_sample = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [CTL_W-1:0]        duty_value;
	logic signed [CTL_W-1:0] control_value;
	logic                    saturated;
	logic                    cfg_we = 1'b0;
	logic [IDX_W-1:0]        cfg_index = '0;
	logic [CFG_W-1:0]        cfg_data = '0;
	int                      mismatches;
	int                      outstanding;

	logic                    dense_phase = 1'b0;
	logic [REF_W-1:0]        cur_setpoint = REFERENCE_RST;

	always #5 clk = ~clk;

	buck_pid_duty_regulator i_dut (.*);

	bpdr_duty_checker i_duty_checker (.*);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [CFG_W-1:0] pick_coef();
		int r;
		r = $urandom_range(0, 15);
		case (r)
			0: return COEF_MIN;
			1: return COEF_MAX;
			2: return COEF_ZERO;
			3, 4: return CFG_W'($urandom);
			default: return CFG_W'($urandom_range(0, 12)) - CFG_W'(6);
		endcase
	endfunction

	function automatic logic [REF_W-1:0] pick_level();
		int v;
		if ($urandom_range(0, 99) < 70) begin
			v = int'(cur_setpoint) + int'($urandom_range(0, 32)) - 16;
			if (v < 0)
				v = 0;
			if (v > 1023)
				v = 1023;
			return REF_W'(v);
		end
		return REF_W'($urandom_range(0, 1023));
	endfunction

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic load_settings(input logic [CFG_W-1:0] sp, b0_v, b1_v, b2_v, a1_v, a2_v);
		write_reg(REG_REFERENCE, sp);
		write_reg(REG_COEF_B0, b0_v);
		write_reg(REG_COEF_B1, b1_v);
		write_reg(REG_COEF_B2, b2_v);
		write_reg(REG_COEF_A1, a1_v);
		write_reg(REG_COEF_A2, a2_v);
		// unmapped indexes must leave every register alone
		write_reg(REG_SPARE_6, CFG_W'($urandom));
		write_reg(REG_SPARE_7, CFG_W'($urandom));
		cfg_we <= 1'b0;
		cur_setpoint = sp[REF_W-1:0];
	endtask

	task automatic offer_level(input logic [REF_W-1:0] level);
		int gap;
		in_valid <= 1'b1;
		adc_sample <= level;
		do @(posedge clk); while (in_stall);
		gap = dense_phase ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic end_phase();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// power-up coefficients
		offer_level(10'd0);
		offer_level(10'd1023);
		offer_level(10'd512);
		offer_level(10'd511);
		offer_level(10'd513);
		offer_level(10'h155);
		offer_level(10'h2AA);
		end_phase();

		// exactly at and one past the upper limit, reference upper bits ignored
		load_settings(16'hFFFF, COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO);
		offer_level(10'd511);
		offer_level(10'd510);
		offer_level(10'd1023);
		end_phase();

		// exactly at and one past the lower limit
		load_settings(16'hFC00, COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO);
		offer_level(10'd512);
		offer_level(10'd513);
		offer_level(10'd0);
		end_phase();

		// widest accumulator swings
		load_settings(16'h0000, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
		offer_level(10'd1023);
		offer_level(10'd1023);
		offer_level(10'd0);
		offer_level(10'd0);
		end_phase();

		load_settings(16'h03FF, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
		offer_level(10'd0);
		offer_level(10'd0);
		offer_level(10'd1023);
		offer_level(10'd1023);
		end_phase();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			dense_phase = (p % 3 == 1);
			load_settings(CFG_W'($urandom), pick_coef(), pick_coef(), pick_coef(),
				pick_coef(), pick_coef());
			repeat (PHASE_REQUESTS) offer_level(pick_level());
			end_phase();
		end

		if (mismatches == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	// result side back-pressure, occasionally long enough to fill the block
	initial begin
		int r;
		@(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end else if (r < 85) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else if (r < 97) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(4, 12)) @(posedge clk);
			end else begin
				out_stall <= 1'b1;
				repeat ($urandom_range(40, 80)) @(posedge clk);
			end
		end
	end

	initial begin
		#10000000;
		$display("testbench: FAIL");
		$finish;
	end

endmodule
